FILE: rtl/rmvb_pkg.sv
// ----------------------------------------------------------------------------
// rmvb_pkg
// shared widths, the state type and the confidence z table for the running
// mean and variance bound core
// ----------------------------------------------------------------------------
package rmvb_pkg;

    localparam int COUNT_BITS  = 24;
    localparam int SAMPLE_BITS = 16;
    localparam int DELTA_BITS  = 49;
    localparam int VAR_BITS    = 31;
    localparam int BOUND_BITS  = 18;
    localparam int SUM_BITS    = 40;
    localparam int SUMSQ_BITS  = 56;
    localparam int ACC_BITS    = 80;
    localparam int REM_BITS    = 48;
    localparam int NQ_BITS     = 64;
    localparam int TAB_LEN     = 10;
    localparam int TDATA_BITS  = 112;

    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [DELTA_BITS-1:0]  delta_t;
    typedef logic [ACC_BITS-1:0]    acc_t;
    typedef logic [4:0]             state_t;

    localparam count_t COUNT_MAX = '1;
    localparam delta_t DELTA_RESET = 49'd281474976711;
    localparam logic [VAR_BITS-1:0] VAR_MAX = 31'd1073741824;
    localparam logic [BOUND_BITS-1:0] BOUND_MAX = '1;
    localparam logic [15:0] Z_BELOW = 16'd32768;

    // deltas in Q0.48, descending
    localparam delta_t DELTA_TAB [TAB_LEN] = '{
        49'd28147497671066, 49'd2814749767107, 49'd281474976711, 49'd28147497671,
        49'd2814749767, 49'd281474977, 49'd80812873, 49'd278695, 49'd363, 49'd9
    };

    // z values in Q4.12
    localparam logic [15:0] Z_TAB [TAB_LEN] = '{
        16'd5249, 16'd9528, 16'd12657, 16'd15234, 16'd17471,
        16'd19531, 16'd20480, 16'd24576, 16'd28672, 16'd30720
    };

endpackage

FILE: rtl/running_mean_variance_bound_core.sv
// ----------------------------------------------------------------------------
// running_mean_variance_bound_core
// running count, mean, unbiased variance, standard deviation and normal
// confidence bound over a stream of signed q8.8 samples
// ----------------------------------------------------------------------------
// each accepted item adds one sample to the count, sum and sum of squares
// unless the count saturated, and returns one item with the count, the q8.8
// mean, the q16.16 variance, its q8.8 square root and the bound z*sqrt(var/n).
// its multiplies, divides and square roots share one 80-bit add/subtract
// unit under a small sequencer: shift-add multiplies, restoring divides and
// digit-by-digit square roots, one bit per cycle; the sample square and the
// bound product have their own multipliers. the variance, deviation and
// bound steps are skipped while the count is below two, and so is the z
// interpolation when delta sits at or above the top of the z table or below
// its bottom. s_tready is high only while the sequencer is idle; the result
// register lets the next item in while an earlier result is still waiting.
// cfg writes delta (q0.48) and must only happen while no item is in flight.
module running_mean_variance_bound_core
    import rmvb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // cfg: confidence delta, unsigned q0.48
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [DELTA_BITS-1:0] cfg_data,
    // s_tdata: [15:0] sample_value
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,
    // m_tdata: [23:0] sample_count, [39:24] mean_value, [70:40] variance_value,
    //          [86:71] std_deviation, [104:87] normal_bound, [111:105] zero
    // m_tuser: [0] stats_valid
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,
    output logic                  m_tuser
);

    // sequencer codes
    localparam state_t S_IDLE     = 5'd0;
    localparam state_t S_MEAN_SET = 5'd1;
    localparam state_t S_MEAN_DIV = 5'd2;
    localparam state_t S_DEN_SET  = 5'd3;
    localparam state_t S_DEN_MUL  = 5'd4;
    localparam state_t S_MULA_SET = 5'd5;
    localparam state_t S_MULA     = 5'd6;
    localparam state_t S_MULB_SET = 5'd7;
    localparam state_t S_MULB     = 5'd8;
    localparam state_t S_VDIV_SET = 5'd9;
    localparam state_t S_VDIV     = 5'd10;
    localparam state_t S_SD_SET   = 5'd11;
    localparam state_t S_SD_SQRT  = 5'd12;
    localparam state_t S_SE_SET   = 5'd13;
    localparam state_t S_SE_DIV   = 5'd14;
    localparam state_t S_SQ_SET   = 5'd15;
    localparam state_t S_SE_SQRT  = 5'd16;
    localparam state_t S_Z_SET    = 5'd17;
    localparam state_t S_Z_MUL    = 5'd18;
    localparam state_t S_ZDIV_SET = 5'd19;
    localparam state_t S_Z_DIV    = 5'd20;
    localparam state_t S_Z_FIN    = 5'd21;
    localparam state_t S_BOUND    = 5'd22;
    localparam state_t S_DONE     = 5'd23;

    // control state
    state_t                       state_reg;
    logic [5:0]                   iter_reg;
    count_t                       count_reg;
    logic signed [SUM_BITS-1:0]   sum_reg;
    logic [SUMSQ_BITS-1:0]        sum_sq_reg;
    delta_t                       delta_reg;

    // datapath working registers
    acc_t                         acc_reg;
    acc_t                         mc_reg;
    logic [SUM_BITS-1:0]          mp_reg;
    logic [REM_BITS-1:0]          rem_reg;
    logic [NQ_BITS-1:0]           nq_reg;
    logic [REM_BITS-1:0]          dvs_reg;
    logic [REM_BITS-1:0]          root_reg;
    logic [REM_BITS-1:0]          bit_reg;

    // per-item results
    logic [15:0]                  mean_reg;
    logic [VAR_BITS-1:0]          var_reg;
    logic [15:0]                  sd_reg;
    logic [23:0]                  se_reg;
    logic [15:0]                  z_reg;
    logic [BOUND_BITS-1:0]        bound_reg;
    logic                         valid_reg;

    // shared arithmetic unit
    acc_t                         alu_a;
    acc_t                         alu_b;
    logic                         alu_sub;
    logic [ACC_BITS:0]            alu_res;
    logic                         alu_ge;
    logic [REM_BITS:0]            div_try;

    logic signed [15:0]           s_x;
    logic signed [31:0]           s_sq;
    logic [SUM_BITS-1:0]          sum_mag;
    logic [SUM_BITS-1:0]          last_iter_pad;
    logic                         last_iter;

    // result hand-over into the output register
    logic                         out_load;

    // z table lookup
    logic                         z_found;
    logic [3:0]                   z_idx;
    logic [3:0]                   z_idx_lo;
    logic                         z_fixed;
    logic [15:0]                  z_fix_val;
    logic [15:0]                  z_lo;
    logic [12:0]                  z_diff;
    logic [44:0]                  d_diff;
    logic [44:0]                  dd_span;

    logic [39:0]                  bound_prod;

    assign s_x       = s_tdata;
    assign s_sq      = s_x * s_x;
    assign sum_mag   = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);
    assign last_iter = (iter_reg == 6'd0);
    assign last_iter_pad = '0;
    assign div_try   = {rem_reg, nq_reg[NQ_BITS-1]};
    assign bound_prod = 40'(z_reg) * 40'(se_reg);
    assign out_load  = (state_reg == S_DONE) && (!m_tvalid || m_tready);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // operand selection for the one adder
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_DEN_MUL, S_MULA, S_Z_MUL:
            begin
                alu_a = acc_reg;
                alu_b = mc_reg;
            end
            S_MULB:
            begin
                alu_a   = acc_reg;
                alu_b   = mc_reg;
                alu_sub = 1'b1;
            end
            S_MEAN_DIV, S_VDIV, S_SE_DIV, S_Z_DIV:
            begin
                alu_a   = ACC_BITS'(div_try);
                alu_b   = ACC_BITS'(dvs_reg);
                alu_sub = 1'b1;
            end
            S_SD_SQRT, S_SE_SQRT:
            begin
                alu_a   = acc_reg;
                alu_b   = ACC_BITS'(root_reg | bit_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res = {1'b0, alu_a} + {1'b0, alu_b ^ {ACC_BITS{alu_sub}}}
                   + (ACC_BITS+1)'(alu_sub);
    assign alu_ge  = alu_res[ACC_BITS];

    // first table entry whose delta is at or below the configured delta
    always_comb
    begin
        z_found = 1'b0;
        z_idx   = 4'd0;
        for (int i = TAB_LEN - 1; i >= 0; i--)
        begin
            if (delta_reg >= DELTA_TAB[i])
            begin
                z_found = 1'b1;
                z_idx   = 4'(i);
            end
        end
    end

    assign z_fixed   = !z_found || (z_idx == 4'd0);
    assign z_fix_val = z_found ? Z_TAB[0] : Z_BELOW;
    assign z_idx_lo  = (z_idx == 4'd0) ? 4'd0 : z_idx - 4'd1;
    assign z_lo      = Z_TAB[z_idx_lo];
    assign z_diff    = 13'(Z_TAB[z_idx] - Z_TAB[z_idx_lo]);
    assign d_diff    = 45'(DELTA_TAB[z_idx_lo] - delta_reg);
    assign dd_span   = 45'(DELTA_TAB[z_idx_lo] - DELTA_TAB[z_idx]);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg <= DELTA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            delta_reg <= cfg_data;
        end
    end

    // sequencer and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            iter_reg   <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            sum_sq_reg <= '0;
            m_tvalid   <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (count_reg != COUNT_MAX)
                        begin
                            count_reg  <= count_reg + 1'b1;
                            sum_reg    <= sum_reg + SUM_BITS'(s_x);
                            sum_sq_reg <= sum_sq_reg + SUMSQ_BITS'(unsigned'(s_sq));
                        end
                        state_reg <= S_MEAN_SET;
                    end
                end
                S_MEAN_SET:
                begin
                    rem_reg   <= REM_BITS'(sum_mag[SUM_BITS-1:16]);
                    nq_reg    <= {sum_mag[15:0], 48'd0};
                    dvs_reg   <= REM_BITS'(count_reg);
                    iter_reg  <= 6'd15;
                    state_reg <= S_MEAN_DIV;
                end
                S_MEAN_DIV, S_VDIV, S_SE_DIV, S_Z_DIV:
                begin
                    rem_reg  <= alu_ge ? alu_res[REM_BITS-1:0] : div_try[REM_BITS-1:0];
                    nq_reg   <= {nq_reg[NQ_BITS-2:0], alu_ge};
                    iter_reg <= iter_reg - 6'd1;
                    if (last_iter)
                    begin
                        case (state_reg)
                            S_MEAN_DIV: state_reg <= S_DEN_SET;
                            S_VDIV:     state_reg <= S_SD_SET;
                            S_SE_DIV:   state_reg <= S_SQ_SET;
                            default:    state_reg <= S_Z_FIN;
                        endcase
                    end
                end
                S_DEN_SET:
                begin
                    if (count_reg == '0)
                    begin
                        mean_reg <= '0;
                    end
                    else if (sum_reg[SUM_BITS-1])
                    begin
                        mean_reg <= -nq_reg[15:0];
                    end
                    else
                    begin
                        mean_reg <= nq_reg[15:0];
                    end
                    if (count_reg < count_t'(2))
                    begin
                        var_reg   <= '0;
                        sd_reg    <= '0;
                        bound_reg <= '0;
                        valid_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        acc_reg   <= '0;
                        mc_reg    <= ACC_BITS'(count_reg);
                        mp_reg    <= SUM_BITS'(count_reg - 1'b1);
                        iter_reg  <= 6'd23;
                        state_reg <= S_DEN_MUL;
                    end
                end
                S_DEN_MUL, S_MULA, S_MULB, S_Z_MUL:
                begin
                    if (mp_reg[0])
                    begin
                        acc_reg <= alu_res[ACC_BITS-1:0];
                    end
                    mc_reg   <= {mc_reg[ACC_BITS-2:0], 1'b0};
                    mp_reg   <= {1'b0, mp_reg[SUM_BITS-1:1]};
                    iter_reg <= iter_reg - 6'd1;
                    if (last_iter)
                    begin
                        case (state_reg)
                            S_DEN_MUL: state_reg <= S_MULA_SET;
                            S_MULA:    state_reg <= S_MULB_SET;
                            S_MULB:    state_reg <= S_VDIV_SET;
                            default:   state_reg <= S_ZDIV_SET;
                        endcase
                    end
                end
                S_MULA_SET:
                begin
                    // n*(n-1) stays in the divisor until the variance divide
                    dvs_reg   <= acc_reg[REM_BITS-1:0];
                    acc_reg   <= '0;
                    mc_reg    <= ACC_BITS'(sum_sq_reg);
                    mp_reg    <= SUM_BITS'(count_reg) | last_iter_pad;
                    iter_reg  <= 6'd23;
                    state_reg <= S_MULA;
                end
                S_MULB_SET:
                begin
                    // subtract sum^2 from n*sumsq in place
                    mc_reg    <= ACC_BITS'(sum_mag);
                    mp_reg    <= sum_mag;
                    iter_reg  <= 6'd39;
                    state_reg <= S_MULB;
                end
                S_VDIV_SET:
                begin
                    rem_reg   <= acc_reg[ACC_BITS-1:32];
                    nq_reg    <= {acc_reg[31:0], 32'd0};
                    iter_reg  <= 6'd31;
                    state_reg <= S_VDIV;
                end
                S_SD_SET:
                begin
                    if (nq_reg[31:0] > 32'(VAR_MAX))
                    begin
                        var_reg <= VAR_MAX;
                        acc_reg <= ACC_BITS'(VAR_MAX);
                    end
                    else
                    begin
                        var_reg <= nq_reg[VAR_BITS-1:0];
                        acc_reg <= ACC_BITS'(nq_reg[VAR_BITS-1:0]);
                    end
                    root_reg  <= '0;
                    bit_reg   <= REM_BITS'(1) << 30;
                    iter_reg  <= 6'd15;
                    state_reg <= S_SD_SQRT;
                end
                S_SD_SQRT, S_SE_SQRT:
                begin
                    if (alu_ge)
                    begin
                        acc_reg  <= alu_res[ACC_BITS-1:0];
                        root_reg <= (root_reg >> 1) | bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg  <= bit_reg >> 2;
                    iter_reg <= iter_reg - 6'd1;
                    if (last_iter)
                    begin
                        state_reg <= (state_reg == S_SD_SQRT) ? S_SE_SET : S_Z_SET;
                    end
                end
                S_SE_SET:
                begin
                    // (var << 16) / n, quotient below 2^46
                    sd_reg    <= root_reg[15:0];
                    rem_reg   <= REM_BITS'(var_reg[VAR_BITS-1]);
                    nq_reg    <= {var_reg[VAR_BITS-2:0], 34'd0};
                    dvs_reg   <= REM_BITS'(count_reg);
                    iter_reg  <= 6'd45;
                    state_reg <= S_SE_DIV;
                end
                S_SQ_SET:
                begin
                    acc_reg   <= ACC_BITS'(nq_reg[45:0]);
                    root_reg  <= '0;
                    bit_reg   <= REM_BITS'(1) << 46;
                    iter_reg  <= 6'd23;
                    state_reg <= S_SE_SQRT;
                end
                S_Z_SET:
                begin
                    se_reg <= root_reg[23:0];
                    if (z_fixed)
                    begin
                        z_reg     <= z_fix_val;
                        state_reg <= S_BOUND;
                    end
                    else
                    begin
                        acc_reg   <= '0;
                        mc_reg    <= ACC_BITS'(d_diff);
                        mp_reg    <= SUM_BITS'(z_diff);
                        iter_reg  <= 6'd12;
                        state_reg <= S_Z_MUL;
                    end
                end
                S_ZDIV_SET:
                begin
                    rem_reg   <= REM_BITS'(acc_reg[57:13]);
                    nq_reg    <= {acc_reg[12:0], 51'd0};
                    dvs_reg   <= REM_BITS'(dd_span);
                    iter_reg  <= 6'd12;
                    state_reg <= S_Z_DIV;
                end
                S_Z_FIN:
                begin
                    z_reg     <= z_lo + 16'(nq_reg[12:0]);
                    state_reg <= S_BOUND;
                end
                S_BOUND:
                begin
                    if (bound_prod[39:20] > 20'(BOUND_MAX))
                    begin
                        bound_reg <= BOUND_MAX;
                    end
                    else
                    begin
                        bound_reg <= bound_prod[37:20];
                    end
                    valid_reg <= 1'b1;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result register, loaded as the sequencer hands over
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata <= {7'd0, bound_reg, sd_reg, var_reg, mean_reg, count_reg};
            m_tuser <= valid_reg;
        end
    end

    // accepted sample either bumps the count or finds it saturated
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=>
            (count_reg == $past(count_reg) + 24'd1) || ($past(count_reg) == COUNT_MAX))
        else $error("count did not advance on an accepted item");

    // stats flag only with at least two samples
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[23:0] >= 24'd2))
        else $error("stats flagged valid below two samples");

    // variance never beyond its clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[70:40] <= VAR_MAX))
        else $error("variance above clamp");

    // invalid stats carry zero variance, deviation and bound
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[104:40] == 65'd0))
        else $error("invalid stats with nonzero fields");

endmodule
